@@ rtl/core/mst_pkg.sv @@
// shared types, codes and helpers for the min tracking stack
package mst_pkg;

	localparam int VAL_W   = 32;
	localparam int ENTRY_W = 34;
	localparam int OCC_W   = 9;
	localparam int CMD_W   = 2;
	localparam int FAULT_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_POP_EMPTY = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_PUSH_FULL = 2'd2;

	localparam logic signed [VAL_W-1:0] VAL_NONE = -32'sd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	// packed from the highest field down, popped_value in the lowest bits
	typedef struct packed {
		logic [OCC_W-1:0]          occupancy;
		logic [FAULT_W-1:0]        fault;
		logic                      is_empty;
		logic signed [VAL_W-1:0]   min_value;
		logic signed [VAL_W-1:0]   top_value;
		logic signed [VAL_W-1:0]   popped_value;
	} result_t;

	localparam int RES_W  = $bits(result_t);
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

	function automatic logic signed [ENTRY_W-1:0] sext_val(input logic signed [VAL_W-1:0] v);
		sext_val = {{(ENTRY_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

	// real value of a stored entry given the current minimum
	function automatic logic signed [VAL_W-1:0] decode_entry(
		input logic signed [ENTRY_W-1:0] e,
		input logic signed [VAL_W-1:0]   m
	);
		logic signed [ENTRY_W-1:0] m34;
		m34 = sext_val(m);
		decode_entry = (e < m34) ? m : e[VAL_W-1:0];
	endfunction

endpackage

@@ rtl/core/mst_entry_ram.sv @@
// entry store: one write port, one registered read port
module mst_entry_ram
	import mst_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic signed [ENTRY_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic signed [ENTRY_W-1:0] rdata
);

	logic signed [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/mst_engine.sv @@
// stack control: count, minimum and cached top entry, ram sequencing
module mst_engine
	import mst_pkg::*;
#(
	parameter int STACK_DEPTH = 256,
	parameter int AW          = 8,
	parameter int CW          = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [CMD_W-1:0]          in_cmd,
	input  logic signed [VAL_W-1:0]   in_value,
	input  logic                      res_free,
	output logic                      res_valid,
	output result_t                   res,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic signed [ENTRY_W-1:0] mem_wdata,
	output logic                      mem_re,
	output logic [AW-1:0]             mem_raddr,
	input  logic signed [ENTRY_W-1:0] mem_rdata
);

	state_t state_q, state_nxt;

	logic [CW-1:0]             count_q;
	logic signed [VAL_W-1:0]   min_q;
	logic signed [ENTRY_W-1:0] top_q;
	logic signed [VAL_W-1:0]   popped_q;

	logic                      accept;
	logic                      full;
	logic                      empty;
	logic                      need_read;
	logic [CW-1:0]             cnt_dec;
	logic signed [ENTRY_W-1:0] v34;
	logic signed [ENTRY_W-1:0] min34;
	logic signed [ENTRY_W-1:0] enc;
	logic signed [ENTRY_W-1:0] restore34;
	logic                      pop_enc;
	logic signed [VAL_W-1:0]   pop_value;
	logic signed [VAL_W-1:0]   pop_min;

	logic [CW-1:0]             nxt_count;
	logic signed [VAL_W-1:0]   nxt_min;
	logic signed [ENTRY_W-1:0] nxt_top;
	logic signed [VAL_W-1:0]   nxt_popped;
	logic [FAULT_W-1:0]        nxt_fault;

	assign accept  = in_valid && in_ready;
	assign full    = (count_q == CW'(STACK_DEPTH));
	assign empty   = (count_q == '0);
	assign cnt_dec = count_q - CW'(1);

	// datapath for the item at the input
	always_comb begin
		v34       = sext_val(in_value);
		min34     = sext_val(min_q);
		enc       = (!empty && (in_value < min_q)) ? ((v34 <<< 1) - min34) : v34;
		restore34 = (min34 <<< 1) - top_q;
		pop_enc   = (top_q < min34);
		pop_value = pop_enc ? min_q : top_q[VAL_W-1:0];
		pop_min   = pop_enc ? restore34[VAL_W-1:0] : min_q;

		nxt_count  = count_q;
		nxt_min    = min_q;
		nxt_top    = top_q;
		nxt_popped = VAL_NONE;
		nxt_fault  = FAULT_NONE;
		need_read  = 1'b0;

		priority if (in_cmd == CMD_PUSH) begin
			if (full) begin
				nxt_fault = FAULT_PUSH_FULL;
			end else begin
				nxt_count = count_q + CW'(1);
				nxt_top   = enc;
				nxt_min   = (empty || (in_value < min_q)) ? in_value : min_q;
			end
		end else if (in_cmd == CMD_POP) begin
			if (empty) begin
				nxt_fault = FAULT_POP_EMPTY;
			end else begin
				nxt_count  = cnt_dec;
				nxt_popped = pop_value;
				nxt_min    = pop_min;
				need_read  = (cnt_dec != '0);
			end
		end else begin
			nxt_count = count_q;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && need_read) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (res_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = enc;
		mem_raddr = cnt_dec[AW-1:0];
		res.popped_value = nxt_popped;
		res.top_value    = (nxt_count == '0) ? VAL_NONE : decode_entry(nxt_top, nxt_min);
		res.min_value    = (nxt_count == '0) ? VAL_NONE : nxt_min;
		res.is_empty     = (nxt_count == '0);
		res.fault        = nxt_fault;
		res.occupancy    = OCC_W'(nxt_count);
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = res_free;
				res_valid = in_valid && res_free && !need_read;
				mem_we    = in_valid && res_free && (in_cmd == CMD_PUSH) && !full;
			end
			ST_READ: begin
				mem_re = 1'b1;
			end
			ST_LOAD: begin
				res_valid        = res_free;
				res.popped_value = popped_q;
				res.top_value    = decode_entry(mem_rdata, min_q);
				res.min_value    = min_q;
				res.is_empty     = 1'b0;
				res.fault        = FAULT_NONE;
				res.occupancy    = OCC_W'(count_q);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			min_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				count_q <= nxt_count;
				min_q   <= nxt_min;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			top_q    <= nxt_top;
			popped_q <= nxt_popped;
		end else if ((state_q == ST_LOAD) && res_free) begin
			top_q <= mem_rdata;
		end
	end

endmodule

@@ rtl/core/min_tracking_stack_core.sv @@
// top level of the min tracking stack with its output register
// Stack of signed 32-bit values that reports top, minimum, empty flag and
// occupancy with every result beat. One command beat (tuser: push, pop or
// query) gives one result beat. Push, query, a faulting pop and a pop that
// empties the stack are answered from the idle state; a pop that leaves
// entries passes through a read state and a load state, since the new top
// entry is reloaded from the entry ram through its registered read port. The
// entry ram needs no clearing after reset. A registered result stage lets a
// new command be taken while the downstream side takes the previous result.
module min_tracking_stack_core
	import mst_pkg::*;
#(
	parameter int STACK_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,  // push_value
	input  logic [1:0]         s_tuser,  // cmd
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata   // popped_value, top_value, min_value, is_empty,
	                                     // fault, occupancy, zero fill
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic                      res_free;
	logic                      res_valid;
	result_t                   res;
	result_t                   res_q;
	logic                      m_tvalid_q;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic signed [ENTRY_W-1:0] mem_wdata;
	logic                      mem_re;
	logic [AW-1:0]             mem_raddr;
	logic signed [ENTRY_W-1:0] mem_rdata;

	assign res_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(TDATA_W-RES_W){1'b0}}, res_q};

	mst_engine #(
		.STACK_DEPTH (STACK_DEPTH),
		.AW          (AW),
		.CW          (CW)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_value  (signed'(s_tdata)),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	mst_entry_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

@@ rtl/core/mst_checker.sv @@
// port level checks for the min tracking stack, bound to the top level
module mst_checker
	import mst_pkg::*;
#(
	parameter int STACK_DEPTH = 256
) (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata
);

	result_t r;
	assign r = m_tdata[RES_W-1:0];

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// empty stack reports no elements and the marker values
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.is_empty |->
			(r.occupancy == '0) && (r.top_value == VAL_NONE) && (r.min_value == VAL_NONE))
		else $error("empty result inconsistent");

	// minimum never above the top element
	a_min_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !r.is_empty |-> (r.min_value <= r.top_value) && (r.occupancy != '0))
		else $error("minimum above top element");

	// a faulting beat removes nothing
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r.fault != FAULT_NONE) |->
			(r.popped_value == VAL_NONE) &&
			((r.fault == FAULT_POP_EMPTY) || (r.fault == FAULT_PUSH_FULL)))
		else $error("faulting beat inconsistent");

	// push on full only when occupancy is at depth
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r.fault == FAULT_PUSH_FULL) |-> (r.occupancy == OCC_W'(STACK_DEPTH)))
		else $error("push fault below full");

endmodule

bind min_tracking_stack_core mst_checker #(.STACK_DEPTH(STACK_DEPTH)) u_mst_checker (.*);

@@ tb/tb.sv @@
// self-checking testbench for the min tracking stack: directed table, then random command beats
module tb;
	import mst_pkg::*;

	localparam int DEPTH          = 256;
	localparam int RAND_ITEMS     = 750;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [CMD_W-1:0]       CMD_UNUSED = 2'd3;
	localparam logic signed [VAL_W-1:0] VAL_MAX   = 32'sh7fffffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN   = 32'sh80000000;

	typedef struct {
		logic [CMD_W-1:0]        cmd;
		logic signed [VAL_W-1:0] value;
		bit                      typed;
		result_t                 status;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [31:0]        s_tdata;  // push_value
	logic [1:0]         s_tuser;  // cmd
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;  // popped_value, top_value, min_value, is_empty,
	                              // fault, occupancy, zero fill

	// shadow copy of the stack
	logic signed [ENTRY_W-1:0] shadow_entries [DEPTH];
	int                        shadow_count;
	logic signed [VAL_W-1:0]   shadow_min;

	result_t  status_due [$];
	dir_row_t dir_table [$];

	int  errors;
	int  beats_in;
	int  beats_out;
	int  n_push;
	int  n_pop;
	int  n_query;
	int  n_full;
	int  n_empty;
	int  peak_occ;
	bit  tx_burst;
	bit  rx_burst;

	min_tracking_stack_core #(
		.STACK_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t mk_status(
		input logic signed [VAL_W-1:0] popped,
		input logic signed [VAL_W-1:0] top,
		input logic signed [VAL_W-1:0] minv,
		input logic                    empty,
		input logic [FAULT_W-1:0]      flt,
		input int                      occ
	);
		result_t r;
		r.popped_value = popped;
		r.top_value    = top;
		r.min_value    = minv;
		r.is_empty     = empty;
		r.fault        = flt;
		r.occupancy    = occ[OCC_W-1:0];
		return r;
	endfunction

	function automatic dir_row_t row(
		input logic [CMD_W-1:0]        c,
		input logic signed [VAL_W-1:0] v,
		input bit                      typed,
		input result_t                 st
	);
		dir_row_t d;
		d.cmd    = c;
		d.value  = v;
		d.typed  = typed;
		d.status = st;
		return d;
	endfunction

	// applies one command to the shadow stack and returns the status beat it yields
	function automatic result_t apply_stack_op(
		input logic [CMD_W-1:0]        c,
		input logic signed [VAL_W-1:0] v
	);
		result_t                   r;
		logic signed [ENTRY_W-1:0] e;
		logic signed [ENTRY_W-1:0] v34;
		logic signed [ENTRY_W-1:0] m34;
		r = mk_status(VAL_NONE, VAL_NONE, VAL_NONE, 1'b0, FAULT_NONE, 0);
		v34 = {{(ENTRY_W-VAL_W){v[VAL_W-1]}}, v};
		m34 = {{(ENTRY_W-VAL_W){shadow_min[VAL_W-1]}}, shadow_min};
		if (c == CMD_PUSH) begin
			if (shadow_count >= DEPTH) begin
				r.fault = FAULT_PUSH_FULL;
			end else begin
				if (shadow_count == 0) begin
					shadow_entries[shadow_count] = v34;
					shadow_min = v;
				end else if (v34 < m34) begin
					// encoded entry marks where the minimum changed
					shadow_entries[shadow_count] = (v34 <<< 1) - m34;
					shadow_min = v;
				end else begin
					shadow_entries[shadow_count] = v34;
				end
				shadow_count++;
			end
		end else if (c == CMD_POP) begin
			if (shadow_count == 0) begin
				r.fault = FAULT_POP_EMPTY;
			end else begin
				shadow_count--;
				e = shadow_entries[shadow_count];
				if (e >= m34) begin
					r.popped_value = e[VAL_W-1:0];
				end else begin
					r.popped_value = shadow_min;
					e = (m34 <<< 1) - e;
					shadow_min = e[VAL_W-1:0];
				end
			end
		end
		if (shadow_count > 0) begin
			e = shadow_entries[shadow_count-1];
			m34 = {{(ENTRY_W-VAL_W){shadow_min[VAL_W-1]}}, shadow_min};
			r.top_value = (e < m34) ? shadow_min : e[VAL_W-1:0];
			r.min_value = shadow_min;
		end
		r.is_empty  = (shadow_count == 0);
		r.occupancy = shadow_count[OCC_W-1:0];
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		int unsigned k;
		k = $urandom_range(0, 9);
		case (k)
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return shadow_min - 1;
			3: return shadow_min;
			4: return shadow_min + 1;
			5, 6: return $signed($urandom_range(0, 40)) - 20;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at result beat %0d, %s: got %0h expected %0h",
			beats_out, what, got, want);
		errors++;
	endtask

	task automatic check_status(input logic [TDATA_W-1:0] data);
		result_t got;
		result_t want;
		got = result_t'(data[RES_W-1:0]);
		if (status_due.size() == 0) begin
			report_mismatch("beat with nothing expected", got.popped_value, 0);
			return;
		end
		want = status_due.pop_front();
		if (got.popped_value !== want.popped_value)
			report_mismatch("popped_value", got.popped_value, want.popped_value);
		if (got.top_value !== want.top_value)
			report_mismatch("top_value", got.top_value, want.top_value);
		if (got.min_value !== want.min_value)
			report_mismatch("min_value", got.min_value, want.min_value);
		if (got.is_empty !== want.is_empty)
			report_mismatch("is_empty", got.is_empty, want.is_empty);
		if (got.fault !== want.fault)
			report_mismatch("fault", got.fault, want.fault);
		if (got.occupancy !== want.occupancy)
			report_mismatch("occupancy", got.occupancy, want.occupancy);
	endtask

	task automatic send_cmd(
		input logic [CMD_W-1:0]        c,
		input logic signed [VAL_W-1:0] v,
		input bit                      typed,
		input result_t                 st
	);
		int      gap;
		result_t pred;
		gap = tx_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			if (s_tvalid) s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_in++;
		pred = apply_stack_op(c, v);
		status_due.push_back(typed ? st : pred);
		case (c)
			CMD_PUSH: n_push++;
			CMD_POP:  n_pop++;
			default:  n_query++;
		endcase
		if (pred.fault == FAULT_PUSH_FULL) n_full++;
		if (pred.fault == FAULT_POP_EMPTY) n_empty++;
		if (shadow_count > peak_occ) peak_occ = shadow_count;
	endtask

	task automatic hold_until_drained();
		if (s_tvalid) s_tvalid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 48)
			send_cmd(CMD_PUSH, pick_value(), 0, '0);
		else if (r < 90)
			send_cmd(CMD_POP, $urandom, 0, '0);
		else if (r < 96)
			send_cmd(CMD_QUERY, $urandom, 0, '0);
		else
			send_cmd(CMD_UNUSED, $urandom, 0, '0);
	endtask

	// result side
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			beats_out++;
			check_status(m_tdata);
		end
	end

	// watchdog on cycles without any beat
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int  sent;
		int  kind;
		int  len;
		bit  filled;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_QUERY;
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		n_push = 0;
		n_pop = 0;
		n_query = 0;
		n_full = 0;
		n_empty = 0;
		peak_occ = 0;
		tx_burst = 0;
		rx_burst = 0;
		shadow_count = 0;
		shadow_min = '0;
		filled = 0;

		dir_table.push_back(row(CMD_QUERY, 0, 1,
			mk_status(VAL_NONE, VAL_NONE, VAL_NONE, 1'b1, FAULT_NONE, 0)));
		dir_table.push_back(row(CMD_POP, 0, 1,
			mk_status(VAL_NONE, VAL_NONE, VAL_NONE, 1'b1, FAULT_POP_EMPTY, 0)));
		dir_table.push_back(row(CMD_UNUSED, 0, 1,
			mk_status(VAL_NONE, VAL_NONE, VAL_NONE, 1'b1, FAULT_NONE, 0)));
		dir_table.push_back(row(CMD_PUSH, VAL_MAX, 1,
			mk_status(VAL_NONE, VAL_MAX, VAL_MAX, 1'b0, FAULT_NONE, 1)));
		dir_table.push_back(row(CMD_PUSH, VAL_MIN, 1,
			mk_status(VAL_NONE, VAL_MIN, VAL_MIN, 1'b0, FAULT_NONE, 2)));
		dir_table.push_back(row(CMD_QUERY, -1, 0, '0));
		dir_table.push_back(row(CMD_PUSH, 0, 0, '0));
		dir_table.push_back(row(CMD_POP, 0, 0, '0));
		dir_table.push_back(row(CMD_POP, 0, 0, '0));
		dir_table.push_back(row(CMD_POP, 0, 1,
			mk_status(VAL_MAX, VAL_NONE, VAL_NONE, 1'b1, FAULT_NONE, 0)));
		dir_table.push_back(row(CMD_PUSH, -5, 0, '0));
		dir_table.push_back(row(CMD_PUSH, -5, 0, '0));
		dir_table.push_back(row(CMD_PUSH, -6, 0, '0));
		dir_table.push_back(row(CMD_PUSH, 3, 0, '0));
		dir_table.push_back(row(CMD_PUSH, VAL_MIN, 0, '0));
		dir_table.push_back(row(CMD_QUERY, 0, 0, '0));
		repeat (5) dir_table.push_back(row(CMD_POP, 0, 0, '0));
		// stale minimum must not leak into a push on empty
		dir_table.push_back(row(CMD_PUSH, 1, 1,
			mk_status(VAL_NONE, 1, 1, 1'b0, FAULT_NONE, 1)));
		dir_table.push_back(row(CMD_PUSH, 32'shaaaaaaaa, 0, '0));
		dir_table.push_back(row(CMD_PUSH, 32'sh55555555, 0, '0));
		dir_table.push_back(row(CMD_POP, 0, 0, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			send_cmd(dir_table[i].cmd, dir_table[i].value, dir_table[i].typed,
				dir_table[i].status);
		hold_until_drained();

		sent = 0;
		while (sent < RAND_ITEMS) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			if (!filled && sent >= 150) begin
				// fill to full, push against full, drain, pop on empty
				filled = 1;
				while (shadow_count < DEPTH) begin
					send_cmd(CMD_PUSH, pick_value(), 0, '0);
					sent++;
				end
				repeat (3) send_cmd(CMD_PUSH, pick_value(), 0, '0);
				send_cmd(CMD_QUERY, 0, 0, '0);
				while (shadow_count > 0) begin
					send_cmd(CMD_POP, $urandom, 0, '0);
					sent++;
				end
				send_cmd(CMD_POP, $urandom, 0, '0);
				sent += 5;
			end else begin
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					len = $urandom_range(10, 40);
					repeat (len) send_random_op();
					sent += len;
				end else if (kind < 8) begin
					len = $urandom_range(5, 30);
					repeat (len) send_cmd(CMD_PUSH, pick_value(), 0, '0);
					sent += len + shadow_count;
					while (shadow_count > 0) send_cmd(CMD_POP, $urandom, 0, '0);
				end else begin
					hold_until_drained();
				end
			end
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (status_due.size() != 0) begin
			void'(status_due.pop_front());
			report_mismatch("expected beat never arrived", 0, 0);
		end

		$display("covered %0d command beats: %0d push, %0d pop, %0d query or unused",
			beats_in, n_push, n_pop, n_query);
		$display("%0d pushes on full, %0d pops on empty, peak occupancy %0d, %0d mismatches",
			n_full, n_empty, peak_occ, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
